// File: design/assert_macros.svh
// Assertion macros shared by the spin heading tracker design files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property on every clock edge outside reset.
`define SHD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spin heading tracker check failed");

// Hold a consequent in the cycle after an antecedent, outside reset.
`define SHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spin heading tracker sequence check failed");

`endif

// File: design/shd_pkg.sv
// Shared types, widths and constants of the spin heading tracker.
// No dependencies; used by every design file by scoped names.
package shd_pkg;

    localparam int S_DATA_W   = 152;
    localparam int M_DATA_W   = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Serial unit sizes
    localparam int SQ_X_W   = 64;
    localparam int SQ_R_W   = 32;
    localparam int SQ_STEPS = SQ_R_W;
    localparam int SQ_CNT_W = $clog2(SQ_STEPS);
    localparam int DIV_N_W  = 64;
    localparam int DIV_D_W  = 25;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int MUL_A_W  = 40;
    localparam int MUL_B_W  = 34;
    localparam int MUL_P_W  = 64;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam logic [29:0] RAD2DEG_Q24 = 30'd961263669;
    localparam logic [24:0] FULL_TURN   = 25'd23592960;
    localparam logic signed [38:0] HALF_TURN_W = 39'sd11796480;
    localparam logic signed [24:0] HALF_TURN_H = 25'sd11796480;
    localparam logic [26:0] HALF_TURN_27 = 27'd11796480;
    localparam logic [26:0] FULL_TURN_27 = 27'd23592960;
    localparam logic [19:0] US_PER_S    = 20'd1000000;
    localparam logic [27:0] SPIN_MAX    = 28'hFFFFFFF;
    localparam logic [23:0] RADIUS_RESET = 24'd12800;
    localparam logic [23:0] RADIUS_MAX  = 24'hFFFFFF;
    localparam logic signed [17:0] OFFSET_MIN = -18'sd131072;
    localparam logic signed [17:0] OFFSET_MAX = 18'sd131071;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_RADIUS   = 3'd0,
        CFG_INITIAL_OFFSET   = 3'd1,
        CFG_STEER_GAIN       = 3'd2,
        CFG_RADIUS_RATE_GAIN = 3'd3,
        CFG_OFFSET_RATE_GAIN = 3'd4
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAG_GO,
        ST_MAG_WAIT,
        ST_Q_GO,
        ST_Q_WAIT,
        ST_W_GO,
        ST_W_WAIT,
        ST_SPIN_GO,
        ST_SPIN_WAIT,
        ST_V,
        ST_D_GO,
        ST_D_WAIT,
        ST_DQ_GO,
        ST_DQ_WAIT,
        ST_WRAP_GO,
        ST_WRAP_WAIT,
        ST_RT_GO,
        ST_RT_WAIT,
        ST_RQ_GO,
        ST_RQ_WAIT,
        ST_OT_GO,
        ST_OT_WAIT,
        ST_OQ_GO,
        ST_OQ_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: design/shd_sqrt.sv
// Bit-pair serial integer square root, one result bit per cycle.
// Depends on shd_pkg.
module shd_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [shd_pkg::SQ_X_W-1:0] radicand,
    output logic [shd_pkg::SQ_R_W-1:0] root,
    output shd_pkg::unit_stat_t        stat
);

    localparam logic [shd_pkg::SQ_CNT_W-1:0] CNT_LAST =
        shd_pkg::SQ_CNT_W'(shd_pkg::SQ_STEPS - 1);

    logic [shd_pkg::SQ_X_W-1:0]   x_reg;
    logic [shd_pkg::SQ_R_W+1:0]   rem_reg;
    logic [shd_pkg::SQ_R_W+1:0]   rem_next;
    logic [shd_pkg::SQ_R_W-1:0]   root_reg;
    logic [shd_pkg::SQ_R_W+3:0]   rem_sh;
    logic [shd_pkg::SQ_R_W+3:0]   trial;
    logic                         ge;
    logic [shd_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    always_comb begin
        rem_sh   = {rem_reg, x_reg[shd_pkg::SQ_X_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = (rem_sh >= trial);
        rem_next = ge ? (shd_pkg::SQ_R_W+2)'(rem_sh - trial)
                      : rem_sh[shd_pkg::SQ_R_W+1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[shd_pkg::SQ_X_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[shd_pkg::SQ_R_W-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/shd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on shd_pkg.
module shd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [shd_pkg::DIV_N_W-1:0] numer,
    input  logic [shd_pkg::DIV_D_W-1:0] denom,
    output logic [shd_pkg::DIV_N_W-1:0] quot,
    output logic [shd_pkg::DIV_D_W-1:0] rem,
    output shd_pkg::unit_stat_t         stat
);

    localparam logic [shd_pkg::DIV_CNT_W-1:0] CNT_LAST =
        shd_pkg::DIV_CNT_W'(shd_pkg::DIV_STEPS - 1);

    logic [shd_pkg::DIV_N_W-1:0]   num_reg;
    logic [shd_pkg::DIV_D_W-1:0]   den_reg;
    logic [shd_pkg::DIV_D_W-1:0]   rem_reg;
    logic [shd_pkg::DIV_D_W-1:0]   rem_next;
    logic [shd_pkg::DIV_D_W:0]     rem_sh;
    logic                          ge;
    logic [shd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    always_comb begin
        rem_sh   = {rem_reg, num_reg[shd_pkg::DIV_N_W-1]};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? shd_pkg::DIV_D_W'(rem_sh - {1'b0, den_reg})
                      : rem_sh[shd_pkg::DIV_D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[shd_pkg::DIV_N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quot      = num_reg;
    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/shd_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on shd_pkg.
module shd_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [shd_pkg::MUL_A_W-1:0] op_a,
    input  logic [shd_pkg::MUL_B_W-1:0] op_b,
    output logic [shd_pkg::MUL_P_W-1:0] prod,
    output shd_pkg::unit_stat_t         stat
);

    localparam logic [shd_pkg::MUL_CNT_W-1:0] CNT_LAST =
        shd_pkg::MUL_CNT_W'(shd_pkg::MUL_STEPS - 1);

    logic [shd_pkg::MUL_P_W-1:0]   a_reg;
    logic [shd_pkg::MUL_B_W-1:0]   b_reg;
    logic [shd_pkg::MUL_P_W-1:0]   acc_reg;
    logic [shd_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= shd_pkg::MUL_P_W'(op_a);
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[shd_pkg::MUL_P_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[shd_pkg::MUL_B_W-1:1]};
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/spin_heading_tracker.sv
// Spin heading tracker: top level with the tick sequencer and datapath registers.
// Depends on shd_pkg, shd_sqrt, shd_div, shd_mul and assert_macros.svh.
//
// Each input transaction is one control tick. The block takes the planar
// acceleration magnitude with a serial square root, divides by the sensor
// radius and takes a second root to get the spin rate, converts it to
// 1/256 deg/s and scales it by (1 + translation*offset), then integrates
// rate plus steering into the heading, wraps the heading to +-180 degrees and
// trims radius and offset by their rate commands. One item is worked at a
// time; s_tready is high only while the sequencer is idle. From acceptance
// until the result is valid a tick makes five passes of the shared 64-step
// divider, four passes of the 34-step shift-add multiplier and two passes of
// the 32-step square root, each with its GO and WAIT states, plus the PREP,
// V and OUT states that form the products, the turn rate and the result.
// A tick whose heading needs no wrap skips one divider pass, and one whose
// scale factor is not positive skips the first multiplier pass. The finished
// result sits in an output register, so the next tick is accepted in the cycle
// after that register is loaded; while an earlier result still waits there,
// hold the new one in the output step.
// Configuration writes to the initial radius or offset also load the working
// radius or offset; a zero radius loads as 1. Write configuration only while
// idle.
module spin_heading_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // accel_x, accel_y, translation, travel_angle, steering,
    // radius_trim, offset_trim, elapsed_us, zero pad
    input  logic [shd_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // heading, right_half, accel_magnitude, spin_rate, radius_now, zero pad
    output logic [shd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [shd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shd_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    shd_pkg::state_t state_reg, state_next;

    // Captured tick fields
    logic signed [20:0] ax_reg, ay_reg;
    logic signed [15:0] trans_reg, steer_reg, rtrim_reg, otrim_reg;
    logic signed [24:0] tangle_reg;
    logic [19:0]        us_reg;
    logic [19:0]        us_in;

    // Configuration and tracker state
    logic [15:0]        steer_gain_reg, radius_gain_reg, offset_gain_reg;
    logic [23:0]        radius_reg;
    logic signed [17:0] offset_reg;
    logic signed [24:0] heading_reg;

    // Intermediate results
    logic [40:0]        ax2_reg, ay2_reg;
    logic signed [33:0] tof_reg;
    logic signed [32:0] sg_reg, rtg_reg, otg_reg;
    logic [20:0]        mag_reg;
    logic [29:0]        base_reg;
    logic [27:0]        spin_reg;
    logic               vneg_reg;
    logic [36:0]        vmag_reg;
    logic signed [38:0] h_reg;
    logic               wrap_up_reg;
    logic               right_reg;

    logic                         m_tvalid_reg;
    logic [shd_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Unit ports
    logic                          sqrt_start, div_start, mul_start;
    logic [shd_pkg::SQ_X_W-1:0]    sqrt_x;
    logic [shd_pkg::SQ_R_W-1:0]    sqrt_root;
    logic [shd_pkg::DIV_N_W-1:0]   div_num, div_quot;
    logic [shd_pkg::DIV_D_W-1:0]   div_den, div_rem;
    logic [shd_pkg::MUL_A_W-1:0]   mul_a;
    logic [shd_pkg::MUL_B_W-1:0]   mul_b;
    logic [shd_pkg::MUL_P_W-1:0]   mul_prod;
    shd_pkg::unit_stat_t           sqrt_stat, div_stat, mul_stat;

    // Combinational datapath terms
    logic signed [41:0] ax_sq, ay_sq;
    logic signed [33:0] tof_prod;
    logic signed [32:0] sg_prod, rtg_prod, otg_prod;
    logic [41:0]        sq_sum;
    logic [30:0]        mag1000;
    logic [61:0]        base_full;
    logic signed [33:0] f_val;
    logic               f_pos;
    logic [32:0]        spin_full;
    logic [27:0]        spin_sat;
    logic signed [37:0] v_val, v_abs;
    logic signed [38:0] dq, h_new, wrap_diff;
    logic               h_above, h_below;
    logic [26:0]        h_wrapped;
    logic signed [25:0] t_val;
    logic signed [32:0] rtg_abs, otg_abs;
    logic signed [25:0] rsum, rdelta;
    logic signed [19:0] osum, odelta;
    logic [23:0]        radius_sat;
    logic signed [17:0] offset_sat;
    logic               load_out;

    shd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_x),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    shd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .quot    (div_quot),
        .rem     (div_rem),
        .stat    (div_stat)
    );

    shd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .prod    (mul_prod),
        .stat    (mul_stat)
    );

    assign s_tready = (state_reg == shd_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign load_out = (state_reg == shd_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        // Cap long gaps at one second
        us_in = (s_tdata[150:131] > shd_pkg::US_PER_S) ? shd_pkg::US_PER_S
                                                       : s_tdata[150:131];

        ax_sq    = ax_reg * ax_reg;
        ay_sq    = ay_reg * ay_reg;
        tof_prod = trans_reg * offset_reg;
        sg_prod  = steer_reg * $signed({1'b0, steer_gain_reg});
        rtg_prod = rtrim_reg * $signed({1'b0, radius_gain_reg});
        otg_prod = otrim_reg * $signed({1'b0, offset_gain_reg});

        sq_sum    = {1'b0, ax2_reg} + {1'b0, ay2_reg};
        mag1000   = 31'(mag_reg) * 31'd1000;
        base_full = 62'(sqrt_root) * 62'(shd_pkg::RAD2DEG_Q24);

        // Scale factor in Q31; drop the rate when it is not positive
        f_val = 34'sh080000000 + tof_reg;
        f_pos = !f_val[33] && (f_val != '0);

        spin_full = mul_prod[63:31];
        spin_sat  = (spin_full[32:28] != '0) ? shd_pkg::SPIN_MAX : spin_full[27:0];

        v_val = $signed({2'b00, spin_reg, 8'h00})
              + $signed({{4{sg_reg[32]}}, sg_reg, 1'b0});
        v_abs = v_val[37] ? -v_val : v_val;

        dq    = $signed({1'b0, div_quot[37:0]});
        h_new = $signed({{14{heading_reg[24]}}, heading_reg}) - (vneg_reg ? -dq : dq);

        h_above   = (h_reg > shd_pkg::HALF_TURN_W);
        h_below   = (h_reg < -shd_pkg::HALF_TURN_W);
        wrap_diff = h_above ? (h_reg - shd_pkg::HALF_TURN_W - 39'sd1)
                            : (-shd_pkg::HALF_TURN_W - h_reg - 39'sd1);
        h_wrapped = wrap_up_reg
            ? (27'(div_rem) + shd_pkg::HALF_TURN_27 + 27'd1 - shd_pkg::FULL_TURN_27)
            : (shd_pkg::FULL_TURN_27 - shd_pkg::HALF_TURN_27 - 27'd1 - 27'(div_rem));

        t_val = $signed({heading_reg[24], heading_reg})
              + $signed({tangle_reg[24], tangle_reg});

        rtg_abs = rtg_reg[32] ? -rtg_reg : rtg_reg;
        otg_abs = otg_reg[32] ? -otg_reg : otg_reg;

        rdelta = $signed({9'b0, div_quot[16:0]});
        rsum   = $signed({2'b00, radius_reg}) + (rtg_reg[32] ? -rdelta : rdelta);
        if (rsum < 26'sd1) begin
            radius_sat = 24'd1;
        end else if (rsum > $signed({2'b00, shd_pkg::RADIUS_MAX})) begin
            radius_sat = shd_pkg::RADIUS_MAX;
        end else begin
            radius_sat = rsum[23:0];
        end

        odelta = $signed({3'b0, div_quot[16:0]});
        osum   = $signed({{2{offset_reg[17]}}, offset_reg})
               + (otg_reg[32] ? -odelta : odelta);
        if (osum < 20'(shd_pkg::OFFSET_MIN)) begin
            offset_sat = shd_pkg::OFFSET_MIN;
        end else if (osum > 20'(shd_pkg::OFFSET_MAX)) begin
            offset_sat = shd_pkg::OFFSET_MAX;
        end else begin
            offset_sat = osum[17:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            shd_pkg::ST_IDLE:      if (s_tvalid) state_next = shd_pkg::ST_PREP;
            shd_pkg::ST_PREP:      state_next = shd_pkg::ST_MAG_GO;
            shd_pkg::ST_MAG_GO:    state_next = shd_pkg::ST_MAG_WAIT;
            shd_pkg::ST_MAG_WAIT:  if (sqrt_stat.done) state_next = shd_pkg::ST_Q_GO;
            shd_pkg::ST_Q_GO:      state_next = shd_pkg::ST_Q_WAIT;
            shd_pkg::ST_Q_WAIT:    if (div_stat.done) state_next = shd_pkg::ST_W_GO;
            shd_pkg::ST_W_GO:      state_next = shd_pkg::ST_W_WAIT;
            shd_pkg::ST_W_WAIT:    if (sqrt_stat.done) state_next = shd_pkg::ST_SPIN_GO;
            shd_pkg::ST_SPIN_GO: begin
                state_next = f_pos ? shd_pkg::ST_SPIN_WAIT : shd_pkg::ST_V;
            end
            shd_pkg::ST_SPIN_WAIT: if (mul_stat.done) state_next = shd_pkg::ST_V;
            shd_pkg::ST_V:         state_next = shd_pkg::ST_D_GO;
            shd_pkg::ST_D_GO:      state_next = shd_pkg::ST_D_WAIT;
            shd_pkg::ST_D_WAIT:    if (mul_stat.done) state_next = shd_pkg::ST_DQ_GO;
            shd_pkg::ST_DQ_GO:     state_next = shd_pkg::ST_DQ_WAIT;
            shd_pkg::ST_DQ_WAIT:   if (div_stat.done) state_next = shd_pkg::ST_WRAP_GO;
            shd_pkg::ST_WRAP_GO: begin
                state_next = (h_above || h_below) ? shd_pkg::ST_WRAP_WAIT
                                                  : shd_pkg::ST_RT_GO;
            end
            shd_pkg::ST_WRAP_WAIT: if (div_stat.done) state_next = shd_pkg::ST_RT_GO;
            shd_pkg::ST_RT_GO:     state_next = shd_pkg::ST_RT_WAIT;
            shd_pkg::ST_RT_WAIT:   if (mul_stat.done) state_next = shd_pkg::ST_RQ_GO;
            shd_pkg::ST_RQ_GO:     state_next = shd_pkg::ST_RQ_WAIT;
            shd_pkg::ST_RQ_WAIT:   if (div_stat.done) state_next = shd_pkg::ST_OT_GO;
            shd_pkg::ST_OT_GO:     state_next = shd_pkg::ST_OT_WAIT;
            shd_pkg::ST_OT_WAIT:   if (mul_stat.done) state_next = shd_pkg::ST_OQ_GO;
            shd_pkg::ST_OQ_GO:     state_next = shd_pkg::ST_OQ_WAIT;
            shd_pkg::ST_OQ_WAIT:   if (div_stat.done) state_next = shd_pkg::ST_OUT;
            shd_pkg::ST_OUT:       if (!m_tvalid_reg || m_tready) state_next = shd_pkg::ST_IDLE;
            default:               state_next = shd_pkg::ST_IDLE;
        endcase
    end

    // Unit starts and operand selection
    always_comb begin
        sqrt_start = 1'b0;
        sqrt_x     = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = 25'd1;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            shd_pkg::ST_MAG_GO: begin
                sqrt_start = 1'b1;
                sqrt_x     = shd_pkg::SQ_X_W'(sq_sum);
            end
            shd_pkg::ST_Q_GO: begin
                // (magnitude * 1000) << 32 over radius
                div_start = 1'b1;
                div_num   = {1'b0, mag1000, 32'h0};
                div_den   = {1'b0, radius_reg};
            end
            shd_pkg::ST_W_GO: begin
                sqrt_start = 1'b1;
                sqrt_x     = div_quot;
            end
            shd_pkg::ST_SPIN_GO: begin
                mul_start = f_pos;
                mul_a     = shd_pkg::MUL_A_W'(base_reg);
                mul_b     = f_val[33:0];
            end
            shd_pkg::ST_D_GO: begin
                mul_start = 1'b1;
                mul_a     = shd_pkg::MUL_A_W'(vmag_reg);
                mul_b     = shd_pkg::MUL_B_W'(us_reg);
            end
            shd_pkg::ST_DQ_GO: begin
                div_start = 1'b1;
                div_num   = mul_prod;
                div_den   = shd_pkg::DIV_D_W'(shd_pkg::US_PER_S);
            end
            shd_pkg::ST_WRAP_GO: begin
                div_start = h_above || h_below;
                div_num   = shd_pkg::DIV_N_W'(unsigned'(wrap_diff));
                div_den   = shd_pkg::FULL_TURN;
            end
            shd_pkg::ST_RT_GO: begin
                mul_start = 1'b1;
                mul_a     = shd_pkg::MUL_A_W'(rtg_abs[31:0]);
                mul_b     = shd_pkg::MUL_B_W'(us_reg);
            end
            shd_pkg::ST_RQ_GO, shd_pkg::ST_OQ_GO: begin
                // Divide by 32768 first, then by one million
                div_start = 1'b1;
                div_num   = {15'h0, mul_prod[63:15]};
                div_den   = shd_pkg::DIV_D_W'(shd_pkg::US_PER_S);
            end
            shd_pkg::ST_OT_GO: begin
                mul_start = 1'b1;
                mul_a     = shd_pkg::MUL_A_W'(otg_abs[31:0]);
                mul_b     = shd_pkg::MUL_B_W'(us_reg);
            end
            default: begin
                sqrt_start = 1'b0;
            end
        endcase
    end

    // Control, configuration and tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= shd_pkg::ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            steer_gain_reg  <= '0;
            radius_gain_reg <= '0;
            offset_gain_reg <= '0;
            radius_reg      <= shd_pkg::RADIUS_RESET;
            offset_reg      <= '0;
            heading_reg     <= '0;
        end else begin
            state_reg <= state_next;

            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    shd_pkg::CFG_INITIAL_RADIUS: begin
                        radius_reg <= (cfg_data == '0) ? 24'd1 : cfg_data;
                    end
                    shd_pkg::CFG_INITIAL_OFFSET:   offset_reg      <= cfg_data[17:0];
                    shd_pkg::CFG_STEER_GAIN:       steer_gain_reg  <= cfg_data[15:0];
                    shd_pkg::CFG_RADIUS_RATE_GAIN: radius_gain_reg <= cfg_data[15:0];
                    shd_pkg::CFG_OFFSET_RATE_GAIN: offset_gain_reg <= cfg_data[15:0];
                    default:                       steer_gain_reg  <= steer_gain_reg;
                endcase
            end

            case (state_reg)
                shd_pkg::ST_WRAP_GO: begin
                    if (!h_above && !h_below) begin
                        heading_reg <= h_reg[24:0];
                    end
                end
                shd_pkg::ST_WRAP_WAIT: begin
                    if (div_stat.done) begin
                        heading_reg <= h_wrapped[24:0];
                    end
                end
                shd_pkg::ST_RQ_WAIT: begin
                    if (div_stat.done) begin
                        radius_reg <= radius_sat;
                    end
                end
                shd_pkg::ST_OQ_WAIT: begin
                    if (div_stat.done) begin
                        offset_reg <= offset_sat;
                    end
                end
                default: begin
                    heading_reg <= heading_reg;
                end
            endcase
        end
    end

    // Tick payload and intermediate results
    always_ff @(posedge aclk) begin
        case (state_reg)
            shd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ax_reg     <= s_tdata[20:0];
                    ay_reg     <= s_tdata[41:21];
                    trans_reg  <= s_tdata[57:42];
                    tangle_reg <= s_tdata[82:58];
                    steer_reg  <= s_tdata[98:83];
                    rtrim_reg  <= s_tdata[114:99];
                    otrim_reg  <= s_tdata[130:115];
                    us_reg     <= us_in;
                end
            end
            shd_pkg::ST_PREP: begin
                ax2_reg <= ax_sq[40:0];
                ay2_reg <= ay_sq[40:0];
                tof_reg <= tof_prod;
                sg_reg  <= sg_prod;
                rtg_reg <= rtg_prod;
                otg_reg <= otg_prod;
            end
            shd_pkg::ST_MAG_WAIT: begin
                if (sqrt_stat.done) begin
                    mag_reg <= sqrt_root[20:0];
                end
            end
            shd_pkg::ST_W_WAIT: begin
                if (sqrt_stat.done) begin
                    base_reg <= base_full[61:32];
                end
            end
            shd_pkg::ST_SPIN_GO: begin
                if (!f_pos) begin
                    spin_reg <= '0;
                end
            end
            shd_pkg::ST_SPIN_WAIT: begin
                if (mul_stat.done) begin
                    spin_reg <= spin_sat;
                end
            end
            shd_pkg::ST_V: begin
                vneg_reg <= v_val[37];
                vmag_reg <= v_abs[36:0];
            end
            shd_pkg::ST_DQ_WAIT: begin
                if (div_stat.done) begin
                    h_reg <= h_new;
                end
            end
            shd_pkg::ST_WRAP_GO: begin
                wrap_up_reg <= h_above;
            end
            shd_pkg::ST_RT_GO: begin
                // Judge the side on the freshly wrapped heading
                right_reg <= (t_val > 26'sd0) && (t_val < $signed({1'b0, shd_pkg::HALF_TURN_H}));
            end
            shd_pkg::ST_OUT: begin
                if (load_out) begin
                    m_tdata_reg <= {5'h0, radius_reg, spin_reg, mag_reg, right_reg,
                                    heading_reg};
                end
            end
            default: begin
                wrap_up_reg <= wrap_up_reg;
            end
        endcase
    end

    `SHD_ASSERT(a_unit_start_idle, aclk, aresetn, !((sqrt_start && sqrt_stat.busy) || (div_start && div_stat.busy) || (mul_start && mul_stat.busy)))
    `SHD_ASSERT_NEXT(a_one_tick_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SHD_ASSERT(a_radius_nonzero, aclk, aresetn, radius_reg != '0)
    `SHD_ASSERT(a_heading_wrapped, aclk, aresetn, (heading_reg <= shd_pkg::HALF_TURN_H) && (heading_reg >= -shd_pkg::HALF_TURN_H))

endmodule
